@@ rtl/i2c_master_bit_engine_assert.svh @@
// Assertion macros for the I2C master bit engine.
// Depends on nothing; included by the top level.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c master bit engine check failed");

// Check that cons holds in the cycle after ante.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c master bit engine check failed");

`endif

@@ rtl/i2cm_pkg.sv @@
// Shared types and constants of the I2C master bit engine.
// Depends on nothing; used by every module of the block.
package i2cm_pkg;

    localparam int unsigned CNT_W = 16;

    localparam logic [CNT_W-1:0] PHASE_TICKS_RST = 16'd10;
    localparam logic [CNT_W-1:0] ACK_TIMEOUT_RST = 16'd200;

    // Configuration register indexes
    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;

    // Command codes
    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_STOP     = 3'd1;
    localparam logic [2:0] CMD_WRITE    = 3'd2;
    localparam logic [2:0] CMD_READ     = 3'd3;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd4;

    // Ack status codes
    localparam logic [1:0] ACK_OK      = 2'd0;
    localparam logic [1:0] ACK_ERROR   = 2'd1;
    localparam logic [1:0] ACK_TIMEOUT = 2'd2;

    localparam logic [2:0] BIT_MSB = 3'd7;

    // Each non-idle state is a point where the bus program waits:
    // a delay phase, or the ack poll loop.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STA_SETUP,
        ST_STA_HOLD,
        ST_STO_LOW,
        ST_STO_SCLHI,
        ST_STO_SDAHI,
        ST_WR_LOW,
        ST_WR_DATA,
        ST_WR_HIGH,
        ST_RD_LOW,
        ST_RD_HIGH,
        ST_RD_ACKLOW,
        ST_RD_ACK,
        ST_RD_NACK,
        ST_RD_NACKLOW,
        ST_AK_DLY,
        ST_AK_POLL,
        ST_AK_HIGH,
        ST_AK_LOW
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] phase_ticks;
        logic [CNT_W-1:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] command;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       ready_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [1:0] ack_status;
    } res_t;

endpackage

@@ rtl/i2cm_bit_core.sv @@
// Tick-driven bus sequencer of the I2C master bit engine.
// Depends on i2cm_pkg.
module i2cm_bit_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  i2cm_pkg::tick_t  tick,
    input  i2cm_pkg::cfg_t   cfg,
    output i2cm_pkg::res_t   res
);

    i2cm_pkg::state_t state_reg, state_next;
    logic [2:0]                   bit_idx_reg, bit_idx_next;
    logic [7:0]                   shift_reg, shift_next;
    logic [i2cm_pkg::CNT_W-1:0]   phase_cnt_reg, phase_cnt_next;
    logic [i2cm_pkg::CNT_W-1:0]   poll_cnt_reg, poll_cnt_next;
    logic                         scl_reg, scl_next;
    logic                         sda_reg, sda_next;
    logic                         ack_flag_reg, ack_flag_next;
    logic [1:0]                   status_reg, status_next;
    logic [7:0]                   rdata_reg, rdata_next;

    logic [i2cm_pkg::CNT_W-1:0]   phase_lim;
    logic [i2cm_pkg::CNT_W-1:0]   poll_lim;
    logic [i2cm_pkg::CNT_W:0]     phase_inc;
    logic [i2cm_pkg::CNT_W:0]     poll_inc;
    logic                         delay_end;
    logic                         poll_limit;
    logic                         do_poll;
    logic                         cmd_known;
    logic                         done;

    // Zero in a timing register acts as one.
    assign phase_lim = (cfg.phase_ticks == '0) ? {{(i2cm_pkg::CNT_W-1){1'b0}}, 1'b1}
                                               : cfg.phase_ticks;
    assign poll_lim  = (cfg.ack_timeout == '0) ? {{(i2cm_pkg::CNT_W-1){1'b0}}, 1'b1}
                                               : cfg.ack_timeout;

    assign phase_inc  = {1'b0, phase_cnt_reg} + {{i2cm_pkg::CNT_W{1'b0}}, 1'b1};
    assign poll_inc   = {1'b0, poll_cnt_reg} + {{i2cm_pkg::CNT_W{1'b0}}, 1'b1};
    assign delay_end  = (phase_inc >= {1'b0, phase_lim});
    assign poll_limit = (poll_inc >= {1'b0, poll_lim});
    assign cmd_known  = (tick.command <= i2cm_pkg::CMD_WAIT_ACK);

    always_comb
    begin
        state_next     = state_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        phase_cnt_next = phase_cnt_reg;
        poll_cnt_next  = poll_cnt_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_flag_next  = ack_flag_reg;
        status_next    = status_reg;
        rdata_next     = rdata_reg;
        done           = 1'b0;
        do_poll        = 1'b0;

        priority if (state_reg == i2cm_pkg::ST_IDLE)
        begin
            if (tick.cmd_valid && cmd_known)
            begin
                bit_idx_next   = i2cm_pkg::BIT_MSB;
                shift_next     = (tick.command == i2cm_pkg::CMD_WRITE) ? tick.write_byte : 8'd0;
                phase_cnt_next = '0;
                poll_cnt_next  = '0;
                ack_flag_next  = tick.send_ack;
                unique case (tick.command)
                    i2cm_pkg::CMD_START:
                    begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        state_next = i2cm_pkg::ST_STA_SETUP;
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        state_next = i2cm_pkg::ST_STO_LOW;
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        scl_next   = 1'b0;
                        state_next = i2cm_pkg::ST_WR_LOW;
                    end
                    i2cm_pkg::CMD_READ:
                    begin
                        scl_next   = 1'b0;
                        state_next = i2cm_pkg::ST_RD_LOW;
                    end
                    default:
                    begin
                        state_next = i2cm_pkg::ST_AK_DLY;
                    end
                endcase
            end
        end
        else if (state_reg == i2cm_pkg::ST_AK_POLL)
        begin
            do_poll = 1'b1;
        end
        else if (!delay_end)
        begin
            phase_cnt_next = phase_inc[i2cm_pkg::CNT_W-1:0];
        end
        else
        begin
            phase_cnt_next = '0;
            unique case (state_reg)
                i2cm_pkg::ST_STA_SETUP:
                begin
                    sda_next   = 1'b0;
                    state_next = i2cm_pkg::ST_STA_HOLD;
                end
                i2cm_pkg::ST_STA_HOLD:
                begin
                    scl_next   = 1'b0;
                    done       = 1'b1;
                    state_next = i2cm_pkg::ST_IDLE;
                end
                i2cm_pkg::ST_STO_LOW:
                begin
                    scl_next   = 1'b1;
                    state_next = i2cm_pkg::ST_STO_SCLHI;
                end
                i2cm_pkg::ST_STO_SCLHI:
                begin
                    sda_next   = 1'b1;
                    state_next = i2cm_pkg::ST_STO_SDAHI;
                end
                i2cm_pkg::ST_STO_SDAHI:
                begin
                    done       = 1'b1;
                    state_next = i2cm_pkg::ST_IDLE;
                end
                i2cm_pkg::ST_WR_LOW:
                begin
                    sda_next   = shift_reg[bit_idx_reg];
                    state_next = i2cm_pkg::ST_WR_DATA;
                end
                i2cm_pkg::ST_WR_DATA:
                begin
                    scl_next   = 1'b1;
                    state_next = i2cm_pkg::ST_WR_HIGH;
                end
                i2cm_pkg::ST_WR_HIGH:
                begin
                    scl_next = 1'b0;
                    if (bit_idx_reg == 3'd0)
                    begin
                        // last bit out: release SDA for the ack slot
                        bit_idx_next = i2cm_pkg::BIT_MSB;
                        sda_next     = 1'b1;
                        done         = 1'b1;
                        state_next   = i2cm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 3'd1;
                        state_next   = i2cm_pkg::ST_WR_LOW;
                    end
                end
                i2cm_pkg::ST_RD_LOW:
                begin
                    scl_next   = 1'b1;
                    state_next = i2cm_pkg::ST_RD_HIGH;
                end
                i2cm_pkg::ST_RD_HIGH:
                begin
                    shift_next[bit_idx_reg] = shift_reg[bit_idx_reg] | tick.sda_in;
                    scl_next = 1'b0;
                    if (bit_idx_reg == 3'd0)
                    begin
                        bit_idx_next = i2cm_pkg::BIT_MSB;
                        state_next   = i2cm_pkg::ST_RD_ACKLOW;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 3'd1;
                        state_next   = i2cm_pkg::ST_RD_LOW;
                    end
                end
                i2cm_pkg::ST_RD_ACKLOW:
                begin
                    scl_next = 1'b1;
                    if (ack_flag_reg)
                    begin
                        sda_next   = 1'b0;
                        state_next = i2cm_pkg::ST_RD_ACK;
                    end
                    else
                    begin
                        sda_next   = 1'b1;
                        state_next = i2cm_pkg::ST_RD_NACK;
                    end
                end
                i2cm_pkg::ST_RD_ACK:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    rdata_next = shift_reg;
                    done       = 1'b1;
                    state_next = i2cm_pkg::ST_IDLE;
                end
                i2cm_pkg::ST_RD_NACK:
                begin
                    scl_next   = 1'b0;
                    state_next = i2cm_pkg::ST_RD_NACKLOW;
                end
                i2cm_pkg::ST_RD_NACKLOW:
                begin
                    rdata_next = shift_reg;
                    done       = 1'b1;
                    state_next = i2cm_pkg::ST_IDLE;
                end
                i2cm_pkg::ST_AK_DLY:
                begin
                    // first poll falls on the tick that ends the opening delay
                    do_poll = 1'b1;
                end
                i2cm_pkg::ST_AK_HIGH:
                begin
                    if (tick.sda_in)
                    begin
                        status_next = i2cm_pkg::ACK_ERROR;
                        done        = 1'b1;
                        state_next  = i2cm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        scl_next   = 1'b0;
                        state_next = i2cm_pkg::ST_AK_LOW;
                    end
                end
                i2cm_pkg::ST_AK_LOW:
                begin
                    status_next = i2cm_pkg::ACK_OK;
                    done        = 1'b1;
                    state_next  = i2cm_pkg::ST_IDLE;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        // Ack poll: low SDA raises SCL for the recheck, high SDA counts a miss
        if (do_poll)
        begin
            if (!tick.sda_in)
            begin
                poll_cnt_next = '0;
                scl_next      = 1'b1;
                state_next    = i2cm_pkg::ST_AK_HIGH;
            end
            else
            begin
                poll_cnt_next = poll_inc[i2cm_pkg::CNT_W-1:0];
                if (poll_limit)
                begin
                    status_next = i2cm_pkg::ACK_TIMEOUT;
                    done        = 1'b1;
                    state_next  = i2cm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = i2cm_pkg::ST_AK_POLL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2cm_pkg::ST_IDLE;
            bit_idx_reg   <= i2cm_pkg::BIT_MSB;
            shift_reg     <= 8'd0;
            phase_cnt_reg <= '0;
            poll_cnt_reg  <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_flag_reg  <= 1'b0;
            status_reg    <= i2cm_pkg::ACK_OK;
            rdata_reg     <= 8'd0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
            phase_cnt_reg <= phase_cnt_next;
            poll_cnt_reg  <= poll_cnt_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_flag_reg  <= ack_flag_next;
            status_reg    <= status_next;
            rdata_reg     <= rdata_next;
        end
    end

    assign res.scl_out    = scl_next;
    assign res.sda_out    = sda_next;
    assign res.ready_res  = (state_next == i2cm_pkg::ST_IDLE);
    assign res.done_res   = done;
    assign res.read_data  = rdata_next;
    assign res.ack_status = status_next;

endmodule

@@ rtl/i2cm_out_skid.sv @@
// Output register with a skid stage for the engine's result stream.
// Depends on i2cm_pkg.
module i2cm_out_skid
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  i2cm_pkg::res_t  in_res,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output i2cm_pkg::res_t  out_res
);

    logic           out_valid_reg;
    logic           skid_valid_reg;
    i2cm_pkg::res_t out_res_reg;
    i2cm_pkg::res_t skid_res_reg;
    logic           out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: refill from the skid first, else take the new result
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : in_res;
        end
        else if (in_valid)
        begin
            skid_res_reg <= in_res;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

@@ rtl/i2c_master_bit_engine.sv @@
// I2C master bit engine: takes one timing tick per clock cycle on the slave
// stream and returns one line-level result per tick on the master stream.
// Every tick transfer is handled as it is accepted: the bus sequencer state
// is updated and the result is registered in the same clock edge, so the
// block sustains one tick per cycle as long as the master side keeps up;
// an output register plus a one-entry skid stage keep the input side open
// for one more transfer while a result is stalled. A tick may carry a command
// (start, stop, write byte, read byte with ack or nack, wait for ack); it is
// taken only when the engine is idle, codes above wait-ack are dropped.
// Each bus phase lasts phase_ticks ticks (register 0); an ack wait polls SDA
// once per tick for up to ack_timeout ticks (register 1) and reports 2 when
// the slave never pulls SDA low, 1 when SDA is high at the recheck, 0 on a
// clean ack. A register value of zero behaves as one. Write configuration
// only while the engine is idle. No clearing pass is needed after reset.
// Depends on i2cm_pkg, i2cm_bit_core, i2cm_out_skid and the assertion header.
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // tick stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // write_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
    input  logic [3:0]  s_tuser,   // cmd_valid[0], command[3:1]

    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // scl_out[0], sda_out[1], ready_res[2], done_res[3],
                                   // read_data[11:4], ack_status[13:12], zero[15:14]
);

    logic [i2cm_pkg::CNT_W-1:0] phase_ticks_reg;
    logic [i2cm_pkg::CNT_W-1:0] ack_timeout_reg;
    i2cm_pkg::cfg_t  cfg;
    i2cm_pkg::tick_t tick;
    i2cm_pkg::res_t  res;
    i2cm_pkg::res_t  out_res;
    logic            step;

    // Configuration registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RST;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == i2cm_pkg::REG_PHASE_TICKS)
            begin
                phase_ticks_reg <= cfg_data;
            end
            else if (cfg_index == i2cm_pkg::REG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg_data;
            end
        end
    end

    assign cfg.phase_ticks = phase_ticks_reg;
    assign cfg.ack_timeout = ack_timeout_reg;

    // Unpack the tick transfer
    assign tick.cmd_valid  = s_tuser[0];
    assign tick.command    = s_tuser[3:1];
    assign tick.write_byte = s_tdata[7:0];
    assign tick.send_ack   = s_tdata[8];
    assign tick.sda_in     = s_tdata[9];

    // Advance the sequencer on every accepted tick
    assign step = s_tvalid && s_tready;

    i2cm_bit_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .tick  (tick),
        .cfg   (cfg),
        .res   (res)
    );

    i2cm_out_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result transfer
    assign m_tdata = {2'b00, out_res.ack_status, out_res.read_data, out_res.done_res,
                      out_res.ready_res, out_res.sda_out, out_res.scl_out};

    // A finished command always leaves the engine idle
    `I2CM_ASSERT_NOW(a_done_idle, clk, rst_n, step && res.done_res, res.ready_res)
    // A full skid stage means the output register is holding a result
    `I2CM_ASSERT_NOW(a_skid_out, clk, rst_n, !s_tready, m_tvalid)
    // A transfer taken while the output is stalled fills the skid stage
    `I2CM_ASSERT_NEXT(a_skid_fill, clk, rst_n, step && m_tvalid && !m_tready, !s_tready)
    // The ack status only ever holds one of its three codes
    `I2CM_ASSERT_NOW(a_status_code, clk, rst_n, step,
        (res.ack_status == i2cm_pkg::ACK_OK) || (res.ack_status == i2cm_pkg::ACK_ERROR) ||
        (res.ack_status == i2cm_pkg::ACK_TIMEOUT))

endmodule
